// File: rtl/b64d_pkg.sv
// Shared types, stop codes and alphabet lookup of the Base64 stream decoder.
`default_nettype none

package b64d_pkg;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_PAD     = 2'd1;
    localparam logic [1:0] CAUSE_INVALID = 2'd2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       end_of_message;
        logic [1:0] stop_cause;
    } out_beat_t;

    typedef struct packed {
        logic [2:0][7:0] byte_data;
        logic [1:0]      cnt;
        logic            byte_valid;
        logic            eom;
        logic [1:0]      cause;
    } group_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        logic [7:0] d;
        r = '{ok: 1'b1, value: 6'd0};
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == CHAR_PLUS) begin
            d = 8'd62;
        end else if (c == CHAR_SLASH) begin
            d = 8'd63;
        end else begin
            r.ok = 1'b0;
        end
        r.value = d[5:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/b64d_front.sv
// Front end: classify each character, gather sextets into byte groups for the queue.
`default_nettype none

module b64d_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire b64d_pkg::in_beat_t beat,
    output logic                  push,
    output b64d_pkg::group_t      rec
);

    logic [17:0] buf_reg, buf_next;
    logic [1:0]  count_reg, count_next;
    logic        stopped_reg, stopped_next;
    logic [1:0]  reason_reg, reason_next;

    b64d_pkg::sextet_t sx;
    logic [23:0]       word;
    logic [1:0]        cause;

    always_comb
    begin
        sx           = b64d_pkg::sextet_of(beat.char_in);
        word         = {buf_reg, sx.value};
        buf_next     = buf_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        reason_next  = reason_reg;
        cause        = (beat.char_in == b64d_pkg::CHAR_PAD) ?
                       b64d_pkg::CAUSE_PAD : b64d_pkg::CAUSE_INVALID;
        rec          = '0;
        rec.byte_valid = 1'b1;
        rec.cause    = b64d_pkg::CAUSE_NONE;

        if (!stopped_reg) begin
            if (sx.ok) begin
                if (count_reg == 2'd3) begin
                    rec.byte_data[0] = word[23:16];
                    rec.byte_data[1] = word[15:8];
                    rec.byte_data[2] = word[7:0];
                    rec.cnt          = 2'd3;
                    buf_next         = '0;
                    count_next       = 2'd0;
                end else begin
                    buf_next   = word[17:0];
                    count_next = count_reg + 2'd1;
                    if (beat.last_in) begin
                        unique case (count_reg)
                            2'd1:
                            begin
                                rec.byte_data[0] = word[11:4];
                                rec.cnt          = 2'd1;
                            end
                            2'd2:
                            begin
                                rec.byte_data[0] = word[17:10];
                                rec.byte_data[1] = word[9:2];
                                rec.cnt          = 2'd2;
                            end
                            default:
                            begin
                                rec.cnt = 2'd0;
                            end
                        endcase
                    end
                end
            end else begin
                rec.cause = cause;
                unique case (count_reg)
                    2'd2:
                    begin
                        rec.byte_data[0] = buf_reg[11:4];
                        rec.cnt          = 2'd1;
                    end
                    2'd3:
                    begin
                        rec.byte_data[0] = buf_reg[17:10];
                        rec.byte_data[1] = buf_reg[9:2];
                        rec.cnt          = 2'd2;
                    end
                    default:
                    begin
                        rec.cnt = 2'd0;
                    end
                endcase
                buf_next     = '0;
                count_next   = 2'd0;
                stopped_next = 1'b1;
                reason_next  = cause;
            end
        end

        if (beat.last_in) begin
            if (rec.cnt == 2'd0) begin
                rec.cnt        = 2'd1;
                rec.byte_valid = 1'b0;
                rec.byte_data  = '0;
                rec.cause      = reason_next;
            end
            rec.eom      = 1'b1;
            buf_next     = '0;
            count_next   = 2'd0;
            stopped_next = 1'b0;
            reason_next  = b64d_pkg::CAUSE_NONE;
        end

        push = accept && (rec.cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_reg     <= '0;
            count_reg   <= 2'd0;
            stopped_reg <= 1'b0;
            reason_reg  <= b64d_pkg::CAUSE_NONE;
        end else if (accept) begin
            buf_reg     <= buf_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            reason_reg  <= reason_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64d_queue.sv
// Short group queue between the front end and the beat sequencer.
`default_nettype none

module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire b64d_pkg::group_t wr_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  not_empty,
    output b64d_pkg::group_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::group_t slots [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        full        = (count_reg == CNT_W'(DEPTH));
        not_empty   = (count_reg != '0);
        rd_data     = slots[rd_ptr_reg];
        wr_ptr_next = push ? advance(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? advance(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full group queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("pop from empty group queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("group queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("group queue pointers differ while empty");

endmodule

`default_nettype wire

// File: rtl/b64d_back.sv
// Back end: split each queued group into output beats, one per cycle while out_stall is low.
`default_nettype none

module b64d_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire b64d_pkg::group_t  q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output b64d_pkg::out_beat_t    out_data
);

    b64d_pkg::group_t cur_reg;
    logic [1:0]       idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             last_beat;
    logic             load;

    always_comb
    begin
        last_beat = (idx_reg == cur_reg.cnt - 2'd1);
        load      = q_valid && (!busy_reg || (!out_stall && last_beat));
        pop       = load;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end else if (busy_reg && !out_stall) begin
            if (last_beat) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end

        out_valid               = busy_reg;
        out_data.byte_out       = cur_reg.byte_data[idx_reg];
        out_data.byte_valid     = cur_reg.byte_valid;
        out_data.end_of_message = cur_reg.eom && last_beat;
        out_data.stop_cause     = cur_reg.cause;
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cur_reg.cnt))
        else $error("beat index outside current group");

    a_no_load_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !last_beat) |-> !pop)
        else $error("group loaded before current one finished");

    a_eom_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.byte_valid) |-> out_data.end_of_message)
        else $error("empty marker without end of message");

endmodule

`default_nettype wire

// File: rtl/base64_stream_decoder.sv
// Top level of the streaming Base64 decoder: front end, group queue and beat sequencer.
//
//  channel | direction | payload     | handshake
//  --------+-----------+-------------+-----------------------
//  in      | input     | in_beat_t   | in_valid / in_stall
//  out     | output    | out_beat_t  | out_valid / out_stall
//
//  One character is taken each cycle while in_stall is low; it is classified and merged in that cycle.
//  Each character yields zero to three output beats, sent one per cycle by the sequencer while out_stall is low.
//  in_stall rises only when the FIFO_DEPTH-entry group queue is full.
//  Reset clears the sextet buffer, stop flag, queue pointers and sequencer at once.
`default_nettype none

module base64_stream_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire b64d_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output b64d_pkg::out_beat_t      out_data
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    b64d_pkg::group_t wr_rec;
    b64d_pkg::group_t rd_rec;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    b64d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (in_data),
        .push   (push),
        .rec    (wr_rec)
    );

    b64d_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (wr_rec),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .rd_data   (rd_rec)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (rd_rec),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
